/* design/c5rc_pkg.sv */
`timescale 1ns / 1ps
// shared constants, types and register codes of the 5x5 replicate-border filter
// no dependencies
package c5rc_pkg;

  localparam int KERNEL_SIZE        = 5;
  localparam int KERNEL_HALF        = KERNEL_SIZE / 2;
  localparam int COEF_BITS          = 12;
  localparam int PIX_W              = 8;
  localparam int REG_W              = 60;
  localparam int DIM_W              = 12;
  localparam int LINE_ROWS          = 8;
  localparam int SLOT_W             = 3;
  localparam int PIXEL_MAX          = 255;
  localparam int DEF_MAX_WIDTH      = 2048;
  localparam int DEF_MAX_HEIGHT     = 2048;
  localparam int DEF_COEF_FRAC_BITS = 8;
  localparam int CFG_IDX_W          = 3;

  localparam logic [REG_W-1:0] KROW_RESET   = '0;
  localparam logic [REG_W-1:0] KROW2_RESET  = 60'h0000_0001_0000_0000;
  localparam logic [DIM_W-1:0] DIM_RESET    = 12'd2048;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KROW0        = 3'd0,
    REG_KROW1        = 3'd1,
    REG_KROW2        = 3'd2,
    REG_KROW3        = 3'd3,
    REG_KROW4        = 3'd4,
    REG_IMAGE_WIDTH  = 3'd5,
    REG_IMAGE_HEIGHT = 3'd6
  } c5rc_reg_e;

  // request kinds
  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } c5rc_req_e;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel_in;
  } c5rc_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_frame;
  } c5rc_out_t;

endpackage

/* design/c5rc_stream_if.sv */
`timescale 1ns / 1ps
// valid/ready stream channel with a typed payload
// payload type is handed in as a parameter (see c5rc_pkg)
interface c5rc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* design/c5rc_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies; read of the address being written returns old data
module c5rc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* design/conv5x5_replicate_clamp.sv */
`timescale 1ns / 1ps
// top level of the 5x5 replicate-border convolution filter
// uses c5rc_pkg, c5rc_stream_if and c5rc_ram
//
// Streams one 8-bit channel in raster order and takes one item per clock,
// pixel or flush, with no bubbles while rsp_o is ready; a result passes
// each pipeline stage and trails the input by two rows and two pixels.
// Flush items drain the pending outputs once a frame is complete, and the
// last output carries end_of_frame. The last eight input rows sit in 40
// block rams of MAX_WIDTH bytes (eight row slots, each copied five times so
// that all five window columns are read in the same cycle); a pixel written
// in the cycle it is needed is forwarded. The rams need no clearing after
// reset. Kernel and size registers are written on the plain write port;
// a size write restarts the frame.
module conv5x5_replicate_clamp
  import c5rc_pkg::*;
#(
  parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  c5rc_stream_if.sink          req_i,
  c5rc_stream_if.source        rsp_o
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int PW  = COEF_BITS + PIX_W + 1;
  localparam int RSW = PW + 3;
  localparam int TW  = PW + 6;

  // configuration registers
  logic [REG_W-1:0] krow_q [KERNEL_SIZE];
  logic [DIM_W-1:0] width_q, height_q;

  // frame position counters
  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;

  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  logic        accept, is_pixel, write_s0, emit_s0, last_s0, restart_cfg;
  logic        mv1, mv2, mv3, mv4, take1, take2, take3, take4;

  logic [SLOT_W-1:0] rd_slot [KERNEL_SIZE];
  logic [AW-1:0]     rd_col  [KERNEL_SIZE];
  logic [SLOT_W-1:0] wr_slot;
  logic [KERNEL_SIZE-1:0] fwd_s0 [KERNEL_SIZE];

  // stage 1: ram read data and side info
  logic                   v1_q, last1_q;
  logic [SLOT_W-1:0]      slot1_q [KERNEL_SIZE];
  logic [KERNEL_SIZE-1:0] fwd1_q  [KERNEL_SIZE];
  logic [PIX_W-1:0]       wdata1_q;
  logic [PIX_W-1:0]       rdata   [KERNEL_SIZE][LINE_ROWS];

  // stage 2: products
  logic                 v2_q, last2_q;
  logic signed [PW-1:0] prod2_q [KERNEL_SIZE][KERNEL_SIZE];
  logic signed [PW-1:0] prod2_d [KERNEL_SIZE][KERNEL_SIZE];

  // stage 3: row sums
  logic                  v3_q, last3_q;
  logic signed [RSW-1:0] rsum3_q [KERNEL_SIZE];
  logic signed [RSW-1:0] rsum3_d [KERNEL_SIZE];

  // stage 4: output register
  logic             v4_q, eof4_q;
  logic [PIX_W-1:0] pix4_q, pix4_d;

  // effective sizes: zero acts as one, clipped to the maximum
  always_comb begin
    if (width_q == '0) begin
      w_eff = CW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = RW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(height_q);
    end
  end

  // pipeline flow
  assign mv4   = v4_q && rsp_o.ready;
  assign take4 = !v4_q || mv4;
  assign mv3   = v3_q && take4;
  assign take3 = !v3_q || mv3;
  assign mv2   = v2_q && take3;
  assign take2 = !v2_q || mv2;
  assign mv1   = v1_q && take2;
  assign take1 = !v1_q || mv1;

  assign req_i.ready = take1;
  assign accept      = req_i.valid && take1;
  assign is_pixel    = (req_i.payload.req_type == REQ_PIXEL);

  // item decode; a pixel emits once it lies two rows and two pixels in,
  // which a one-pixel-wide image reaches only on its fifth row
  always_comb begin
    write_s0 = accept && is_pixel && (in_row_q < h_eff) && (in_col_q < w_eff);
    if (is_pixel) begin
      emit_s0 = write_s0 && ((in_row_q >= RW'(KERNEL_HALF + 2)) ||
                ((in_row_q == RW'(KERNEL_HALF + 1)) && (w_eff >= CW'(2))) ||
                ((in_row_q == RW'(KERNEL_HALF)) && (in_col_q >= CW'(KERNEL_HALF))));
    end else begin
      emit_s0 = accept && (in_row_q >= h_eff) && (out_row_q < h_eff);
    end
    last_s0 = (out_row_q >= h_eff - RW'(1)) && (out_col_q >= w_eff - CW'(1));
    restart_cfg = cfg_we_i && ((cfg_index_i == REG_IMAGE_WIDTH) ||
                               (cfg_index_i == REG_IMAGE_HEIGHT));
  end

  // counter updates
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (write_s0) begin
      if (in_col_q + CW'(1) >= w_eff) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
    end
    if (emit_s0) begin
      if (last_s0) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else if (out_col_q + CW'(1) >= w_eff) begin
        out_col_d = '0;
        out_row_d = out_row_q + RW'(1);
      end else begin
        out_col_d = out_col_q + CW'(1);
      end
    end
    if (restart_cfg) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  // window addresses with replicated borders, and forwarding of the new pixel
  always_comb begin
    logic signed [RW+1:0] rs;
    logic signed [CW+1:0] cs;
    logic [RW-1:0]        rc;
    logic [CW-1:0]        cc;
    wr_slot = in_row_q[SLOT_W-1:0];
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      rs = $signed({2'b00, out_row_q}) + (RW+2)'(k) - (RW+2)'(KERNEL_HALF);
      if (rs < 0) begin
        rc = '0;
      end else if (rs > $signed({2'b00, h_eff - RW'(1)})) begin
        rc = h_eff - RW'(1);
      end else begin
        rc = rs[RW-1:0];
      end
      rd_slot[k] = rc[SLOT_W-1:0];
    end
    for (int l = 0; l < KERNEL_SIZE; l++) begin
      cs = $signed({2'b00, out_col_q}) + (CW+2)'(l) - (CW+2)'(KERNEL_HALF);
      if (cs < 0) begin
        cc = '0;
      end else if (cs > $signed({2'b00, w_eff - CW'(1)})) begin
        cc = w_eff - CW'(1);
      end else begin
        cc = cs[CW-1:0];
      end
      rd_col[l] = cc[AW-1:0];
    end
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      for (int l = 0; l < KERNEL_SIZE; l++) begin
        fwd_s0[k][l] = write_s0 && (rd_slot[k] == wr_slot) &&
                       (rd_col[l] == in_col_q[AW-1:0]);
      end
    end
  end

  // line store: one ram per row slot and window column
  for (genvar l = 0; l < KERNEL_SIZE; l++) begin : g_copy
    for (genvar s = 0; s < LINE_ROWS; s++) begin : g_slot
      c5rc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
      ) u_ram (
        .clk_i   (clk_i),
        .we_i    (write_s0 && (wr_slot == SLOT_W'(s))),
        .waddr_i (in_col_q[AW-1:0]),
        .wdata_i (req_i.payload.pixel_in),
        .re_i    (emit_s0),
        .raddr_i (rd_col[l]),
        .rdata_o (rdata[l][s])
      );
    end
  end

  // products of window pixels and coefficients
  always_comb begin
    logic [PIX_W-1:0]            px;
    logic signed [COEF_BITS-1:0] coef;
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      for (int l = 0; l < KERNEL_SIZE; l++) begin
        px   = fwd1_q[k][l] ? wdata1_q : rdata[l][slot1_q[k]];
        coef = $signed(krow_q[k][COEF_BITS*l +: COEF_BITS]);
        prod2_d[k][l] = PW'(coef) * $signed({{(PW-PIX_W){1'b0}}, px});
      end
    end
  end

  // row sums
  always_comb begin
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      rsum3_d[k] = '0;
      for (int l = 0; l < KERNEL_SIZE; l++) begin
        rsum3_d[k] = rsum3_d[k] + RSW'(prod2_q[k][l]);
      end
    end
  end

  // total, round to nearest, scale and clamp
  always_comb begin
    logic signed [TW-1:0] t;
    logic signed [TW-1:0] s;
    t = TW'(1) <<< (COEF_FRAC_BITS - 1);
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      t = t + TW'(rsum3_q[k]);
    end
    s = t >>> COEF_FRAC_BITS;
    if (t < 0) begin
      pix4_d = '0;
    end else if (s > TW'(PIXEL_MAX)) begin
      pix4_d = PIX_W'(PIXEL_MAX);
    end else begin
      pix4_d = s[PIX_W-1:0];
    end
  end

  // configuration and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        krow_q[k] <= (k == KERNEL_HALF) ? KROW2_RESET : KROW_RESET;
      end
      width_q   <= DIM_RESET;
      height_q  <= DIM_RESET;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (c5rc_reg_e'(cfg_index_i))
          REG_KROW0:        krow_q[0] <= cfg_data_i;
          REG_KROW1:        krow_q[1] <= cfg_data_i;
          REG_KROW2:        krow_q[2] <= cfg_data_i;
          REG_KROW3:        krow_q[3] <= cfg_data_i;
          REG_KROW4:        krow_q[4] <= cfg_data_i;
          REG_IMAGE_WIDTH:  width_q   <= cfg_data_i[DIM_W-1:0];
          REG_IMAGE_HEIGHT: height_q  <= cfg_data_i[DIM_W-1:0];
          default: ;
        endcase
      end
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (take1) v1_q <= emit_s0;
      if (take2) v2_q <= mv1;
      if (take3) v3_q <= mv2;
      if (take4) v4_q <= mv3;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (emit_s0) begin
      last1_q  <= last_s0;
      wdata1_q <= req_i.payload.pixel_in;
      slot1_q  <= rd_slot;
      fwd1_q   <= fwd_s0;
    end
    if (mv1) begin
      last2_q <= last1_q;
      prod2_q <= prod2_d;
    end
    if (mv2) begin
      last3_q <= last2_q;
      rsum3_q <= rsum3_d;
    end
    if (mv3) begin
      eof4_q <= last3_q;
      pix4_q <= pix4_d;
    end
  end

  assign rsp_o.valid                = v4_q;
  assign rsp_o.payload.pixel_out    = pix4_q;
  assign rsp_o.payload.end_of_frame = eof4_q;

endmodule

/* tb/conv5x5_replicate_clamp_tb.sv */
`timescale 1ns / 1ps
// testbench of the 5x5 replicate-border convolution filter: random frames and kernels
// checked item by item against an in-bench line-store predictor
// depends on c5rc_pkg, c5rc_stream_if and conv5x5_replicate_clamp
module conv5x5_replicate_clamp_tb;
  import c5rc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
  localparam int MAXW        = DEF_MAX_WIDTH;
  localparam int MAXH        = DEF_MAX_HEIGHT;
  localparam int FRAC        = DEF_COEF_FRAC_BITS;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYC   = 8;
  localparam int RANDOM_ITEMS = 950;
  localparam logic [COEF_BITS-1:0] COEF_MOST_NEG = 12'h800;
  localparam logic [COEF_BITS-1:0] COEF_MOST_POS = 12'h7FF;
  localparam logic [COEF_BITS-1:0] COEF_ONE      = 12'h100;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [REG_W-1:0] cfg_data_i;

  c5rc_stream_if #(.payload_t(c5rc_in_t))  req_if ();
  c5rc_stream_if #(.payload_t(c5rc_out_t)) rsp_if ();

  conv5x5_replicate_clamp DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // predictor state
  logic [REG_W-1:0] kern_rows [KERNEL_SIZE];
  logic [DIM_W-1:0] width_reg, height_reg;
  logic [PIX_W-1:0] row_slots [LINE_ROWS][MAXW];
  int unsigned in_col, in_row, out_col, out_row;

  c5rc_out_t filtered_q [$];
  int errors;
  int sent_items;
  bit quiet;
  int idle_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void restart_frame();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  // one filtered pixel at the output position, then advance it
  function automatic void filter_pixel();
    int unsigned w, h;
    longint acc;
    int rr, cc;
    logic signed [COEF_BITS-1:0] coef;
    c5rc_out_t res;
    bit last;
    w = eff_dim(width_reg, MAXW);
    h = eff_dim(height_reg, MAXH);
    acc = 0;
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      rr = clip(int'(out_row) - KERNEL_HALF + k, 0, int'(h) - 1);
      for (int l = 0; l < KERNEL_SIZE; l++) begin
        cc = clip(int'(out_col) - KERNEL_HALF + l, 0, int'(w) - 1);
        coef = kern_rows[k][COEF_BITS*l +: COEF_BITS];
        acc += longint'(coef) * longint'(row_slots[rr % LINE_ROWS][cc]);
      end
    end
    acc += longint'(1) << (FRAC - 1);
    if (acc < 0) res.pixel_out = '0;
    else if ((acc >>> FRAC) > PIXEL_MAX) res.pixel_out = PIX_W'(PIXEL_MAX);
    else res.pixel_out = PIX_W'(acc >>> FRAC);
    last = (out_row >= h - 1) && (out_col >= w - 1);
    res.end_of_frame = last;
    filtered_q.insert(filtered_q.size(), res);
    if (last) begin
      restart_frame();
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endfunction

  // predict the effect of one accepted request item
  function automatic void predict_item(c5rc_in_t it);
    int unsigned w, h, pos;
    w = eff_dim(width_reg, MAXW);
    h = eff_dim(height_reg, MAXH);
    if (it.req_type == REQ_FLUSH) begin
      if (in_row >= h && out_row < h) filter_pixel();
      return;
    end
    if (in_row >= h || in_col >= w) return;
    pos = in_row * w + in_col;
    row_slots[in_row % LINE_ROWS][in_col] = it.pixel_in;
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    if (pos >= KERNEL_HALF * w + KERNEL_HALF) filter_pixel();
  endfunction

  // send one item, waiting for the handshake
  task automatic send_item(c5rc_req_e kind, logic [PIX_W-1:0] px);
    c5rc_in_t it;
    it.req_type = kind;
    it.pixel_in = px;
    while (!quiet && $urandom_range(99) < 10) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= it;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_item(it);
    sent_items++;
  endtask

  // wait for every expected item, then let the pipeline empty
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_KROW0, REG_KROW1, REG_KROW2, REG_KROW3, REG_KROW4:
        kern_rows[idx] = data;
      REG_IMAGE_WIDTH: begin
        width_reg = data[DIM_W-1:0];
        restart_frame();
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = data[DIM_W-1:0];
        restart_frame();
      end
      default: ;
    endcase
  endtask

  // size writes carry random upper bits, which the block drops
  task automatic set_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, {$urandom, 16'($urandom), w});
    write_reg(REG_IMAGE_HEIGHT, {$urandom, 16'($urandom), h});
  endtask

  function automatic logic [REG_W-1:0] fill_row(logic [COEF_BITS-1:0] c);
    return {KERNEL_SIZE{c}};
  endfunction

  function automatic logic [REG_W-1:0] random_row();
    logic [REG_W-1:0] r;
    for (int l = 0; l < KERNEL_SIZE; l++) begin
      if ($urandom_range(9) == 0) r[COEF_BITS*l +: COEF_BITS] = COEF_BITS'($urandom);
      else r[COEF_BITS*l +: COEF_BITS] = COEF_BITS'($urandom_range(160) - 80);
    end
    return r;
  endfunction

  task automatic set_kernel(logic [REG_W-1:0] r0, logic [REG_W-1:0] r1,
                            logic [REG_W-1:0] r2, logic [REG_W-1:0] r3,
                            logic [REG_W-1:0] r4);
    write_reg(REG_KROW0, r0);
    write_reg(REG_KROW1, r1);
    write_reg(REG_KROW2, r2);
    write_reg(REG_KROW3, r3);
    write_reg(REG_KROW4, r4);
  endtask

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return PIX_W'(PIXEL_MAX);
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // one whole frame at the current size, with optional ignored items mixed in
  task automatic run_frame(bit noisy);
    int unsigned w, h;
    w = eff_dim(width_reg, MAXW);
    h = eff_dim(height_reg, MAXH);
    for (int unsigned i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(19) == 0) send_item(REQ_FLUSH, random_pixel());
      send_item(REQ_PIXEL, random_pixel());
    end
    if (noisy && $urandom_range(2) == 0) send_item(REQ_PIXEL, random_pixel());
    while (in_row >= h && out_row < h) send_item(REQ_FLUSH, random_pixel());
  endtask

  task automatic test_identity_frame();
    set_size(12'd5, 12'd4);
    for (int i = 0; i < 20; i++)
      send_item(REQ_PIXEL, (i % 2) ? PIX_W'(PIXEL_MAX) : PIX_W'(0));
    // extra pixel past frame end is ignored
    send_item(REQ_PIXEL, 8'hA5);
    while (in_row >= 4 && out_row < 4) send_item(REQ_FLUSH, 8'h5A);
    // early flush in a fresh frame is ignored
    send_item(REQ_FLUSH, 8'h00);
    run_frame(1'b0);
  endtask

  task automatic test_kernel_extremes();
    set_size(12'd3, 12'd3);
    set_kernel(fill_row(COEF_MOST_NEG), fill_row(COEF_MOST_NEG), fill_row(COEF_MOST_NEG),
               fill_row(COEF_MOST_NEG), fill_row(COEF_MOST_NEG));
    run_frame(1'b0);
    set_kernel(fill_row(COEF_MOST_POS), fill_row(COEF_MOST_POS), fill_row(COEF_MOST_POS),
               fill_row(COEF_MOST_POS), fill_row(COEF_MOST_POS));
    run_frame(1'b0);
    // rounding: half-weights produce ties
    set_kernel('0, '0, fill_row(12'h080), '0, '0);
    run_frame(1'b0);
    set_kernel('0, {12'h000, 12'hF00, COEF_ONE, 12'h000, 12'h000}, '0, '0, '0);
    run_frame(1'b0);
    write_reg(CFG_IDX_UNUSED, {REG_W{1'b1}});
    run_frame(1'b0);
  endtask

  task automatic test_size_extremes();
    set_kernel(random_row(), random_row(), random_row(), random_row(), random_row());
    set_size(12'd1, 12'd1);
    run_frame(1'b0);
    set_size(12'd0, 12'd0);
    run_frame(1'b0);
    // single-column image: outputs start only on the fifth row
    set_size(12'd1, 12'd7);
    run_frame(1'b0);
    set_size(12'd2, 12'd6);
    run_frame(1'b0);
    set_size(12'd40, 12'd2);
    run_frame(1'b0);
    // size write in the middle of a frame drops it
    set_size(12'd6, 12'd5);
    for (int i = 0; i < 17; i++) send_item(REQ_PIXEL, random_pixel());
    set_size(12'd4, 12'd6);
    run_frame(1'b1);
  endtask

  task automatic test_random_frames();
    int start;
    start = sent_items;
    while (sent_items - start < RANDOM_ITEMS) begin
      if ($urandom_range(2) == 0)
        set_kernel(random_row(), random_row(), random_row(), random_row(), random_row());
      if ($urandom_range(4) == 0) set_size(12'($urandom_range(10, 40)), 12'($urandom_range(1, 4)));
      else set_size(12'($urandom_range(1, 9)), 12'($urandom_range(1, 8)));
      quiet = ($urandom_range(7) == 0);
      run_frame($urandom_range(3) == 0);
      quiet = 1'b0;
    end
  endtask

  // receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= quiet || ($urandom_range(99) >= 10);
    end
  end

  // compare each result item with the oldest prediction
  always @(posedge clk_i) begin
    c5rc_out_t exp_res;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual pixel_out=%0d end_of_frame=%0b",
                 $time, rsp_if.payload.pixel_out, rsp_if.payload.end_of_frame);
        errors++;
      end else begin
        exp_res = filtered_q.pop_front();
        if (rsp_if.payload.pixel_out !== exp_res.pixel_out) begin
          $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                   $time, exp_res.pixel_out, rsp_if.payload.pixel_out);
          errors++;
        end
        if (rsp_if.payload.end_of_frame !== exp_res.end_of_frame) begin
          $display("%0t: end_of_frame mismatch, expected %0b, actual %0b",
                   $time, exp_res.end_of_frame, rsp_if.payload.end_of_frame);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("conv5x5_replicate_clamp_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // test sequence
  initial begin
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rst_ni         = 1'b0;
    errors         = 0;
    sent_items     = 0;
    quiet          = 1'b0;
    for (int k = 0; k < KERNEL_SIZE; k++) kern_rows[k] = KROW_RESET;
    kern_rows[2] = KROW2_RESET;
    width_reg  = DIM_RESET;
    height_reg = DIM_RESET;
    restart_frame();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity_frame();
    test_kernel_extremes();
    test_size_extremes();
    test_random_frames();
    settle();
    if (errors == 0) begin
      $display("conv5x5_replicate_clamp_tb OK");
    end else begin
      $display("conv5x5_replicate_clamp_tb NOT OK");
    end
    $finish;
  end

endmodule

/* conv5x5_replicate_clamp.f */
design/c5rc_pkg.sv
design/c5rc_stream_if.sv
design/c5rc_ram.sv
design/conv5x5_replicate_clamp.sv
tb/conv5x5_replicate_clamp_tb.sv
